/* rtl/core/spq_pkg.sv */
package spq_pkg;

  // Sizes
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PRIO_BITS = 16;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  // Request action codes
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_e;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP
  } cmd_e;

  typedef struct packed {
    logic signed [PRIO_BITS-1:0] prio;
    logic        [TAG_BITS-1:0]  tag;
  } slot_t;

  typedef struct packed {
    cmd_e  cmd;
    slot_t ins;
  } ctrl_t;

  // What a cell hands to its upper neighbour
  typedef struct packed {
    slot_t slot;
    logic  le;    // occupied and priority <= inserted priority
  } link_t;

endpackage

/* rtl/core/spq_intf.sv */
// Request channel
interface spq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [spq_pkg::PRIO_BITS-1:0] priority_req;
  logic        [spq_pkg::TAG_BITS-1:0]  tag;

  modport source (output valid, action, priority_req, tag, input ready);
  modport sink   (input valid, action, priority_req, tag, output ready);
endinterface

// Result channel
interface spq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 popped_valid;
  logic signed [spq_pkg::PRIO_BITS-1:0] out_priority;
  logic        [spq_pkg::TAG_BITS-1:0]  out_tag;
  logic                                 is_empty;
  logic        [spq_pkg::CNT_BITS-1:0]  entry_count;
  logic        [1:0]                    error_code;

  modport source (output valid, popped_valid, out_priority, out_tag, is_empty,
                  entry_count, error_code, input ready);
  modport sink   (input valid, popped_valid, out_priority, out_tag, is_empty,
                  entry_count, error_code, output ready);
endinterface

/* rtl/core/spq_cell.sv */
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::ctrl_t  ctrl_i,
  input  logic            occ_i,    // this slot holds an entry
  input  spq_pkg::link_t  left_i,   // neighbour nearer the head
  input  spq_pkg::slot_t  right_i,  // neighbour nearer the tail
  output spq_pkg::link_t  link_o
);

  spq_pkg::slot_t slot_q, slot_d;
  logic           mine_le;

  // Held entry goes no later than the new one
  assign mine_le = occ_i && (slot_q.prio <= ctrl_i.ins.prio);

  assign link_o.slot = slot_q;
  assign link_o.le   = mine_le;

  // Keep, take the new word, or shift from a neighbour
  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.cmd)
      spq_pkg::CMD_INSERT: begin
        if (mine_le) begin
          slot_d = slot_q;
        end else if (left_i.le) begin
          slot_d = ctrl_i.ins;
        end else begin
          slot_d = left_i.slot;
        end
      end
      spq_pkg::CMD_POP: begin
        slot_d = right_i;
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue, lowest priority first. Up to DEPTH entries sit in a
// chain of cells kept in ascending signed priority; an insert lands behind
// every held entry of lower or equal priority, so equal priorities leave in
// arrival order, and a pop returns the head entry. Every request word yields
// exactly one result word carrying the popped entry (zero otherwise), the
// empty flag, the fill count after the request and an error code (insert
// into a full queue or pop from an empty one is dropped and flagged). On a
// request all cells compare against the new priority in parallel and shift in
// the same clock, and the result is registered, so a new request is taken
// every cycle while the result register is free or being read. The result
// appears on the cycle after acceptance.
module sorted_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  spq_req_if.sink           req_i,
  spq_rsp_if.source         rsp_o
);

  localparam int unsigned N = spq_pkg::DEPTH;
  localparam int unsigned C = spq_pkg::CNT_BITS;

  logic [C-1:0]   count_q, count_d;
  logic           out_valid_q;
  logic           popped_q;
  spq_pkg::slot_t out_slot_q, out_slot_d;
  logic [C-1:0]   out_count_q;
  spq_pkg::err_e  err_q, err_d;

  logic           accept;
  logic           full, empty;
  logic           popped_d;
  spq_pkg::ctrl_t ctrl;
  spq_pkg::link_t link [N];

  assign full   = (count_q == C'(N));
  assign empty  = (count_q == '0);
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;

  // Decode the request into a cell command and the result
  always_comb begin
    ctrl.cmd      = spq_pkg::CMD_HOLD;
    ctrl.ins.prio = req_i.priority_req;
    ctrl.ins.tag  = req_i.tag;
    count_d       = count_q;
    popped_d      = 1'b0;
    out_slot_d    = '0;
    err_d         = spq_pkg::ERR_OK;
    if (accept) begin
      case (spq_pkg::action_e'(req_i.action))
        spq_pkg::ACT_INSERT: begin
          if (full) begin
            err_d = spq_pkg::ERR_FULL;
          end else begin
            ctrl.cmd = spq_pkg::CMD_INSERT;
            count_d  = count_q + C'(1);
          end
        end
        spq_pkg::ACT_POP: begin
          if (empty) begin
            err_d = spq_pkg::ERR_EMPTY;
          end else begin
            ctrl.cmd   = spq_pkg::CMD_POP;
            count_d    = count_q - C'(1);
            popped_d   = 1'b1;
            out_slot_d = link[0].slot;
          end
        end
        default: begin
          err_d = spq_pkg::ERR_OK;
        end
      endcase
    end
  end

  // Cell chain, head at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::link_t left;
    spq_pkg::slot_t right;

    if (i == 0) begin : g_head
      assign left = '{slot: '0, le: 1'b1};
    end else begin : g_mid
      assign left = link[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = link[i+1].slot;
    end

    spq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .occ_i  (count_q > C'(i)),
      .left_i (left),
      .right_i(right),
      .link_o (link[i])
    );
  end

  // Fill count and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= popped_d;
      out_slot_q  <= out_slot_d;
      out_count_q <= count_d;
      err_q       <= err_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_valid = popped_q;
  assign rsp_o.out_priority = out_slot_q.prio;
  assign rsp_o.out_tag      = out_slot_q.tag;
  assign rsp_o.is_empty     = (out_count_q == '0);
  assign rsp_o.entry_count  = out_count_q;
  assign rsp_o.error_code   = err_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= C'(N))
    else $error("fill count beyond depth");

  a_pop_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.action == spq_pkg::ACT_POP && !empty
      |=> rsp_o.valid && rsp_o.popped_valid && rsp_o.error_code == spq_pkg::ERR_OK)
    else $error("pop from non-empty queue returned nothing");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.action == spq_pkg::ACT_INSERT && !full
      |=> count_q == $past(count_q) + C'(1))
    else $error("insert did not grow the fill count");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.entry_count == count_q)
    else $error("reported count differs from held count");

endmodule

/* tb/sorted_priority_queue_tb.sv */
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned SHOW_LIMIT  = 10;

  // What one result word should carry
  typedef struct packed {
    logic                        popped;
    logic signed [PRIO_BITS-1:0] prio;
    logic        [TAG_BITS-1:0]  tag;
    logic                        empty;
    logic        [CNT_BITS-1:0]  count;
    logic        [1:0]           err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the queue contents, head first
  slot_t   held_slots[$];
  result_t awaited_results[$];

  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_INSERT;
    req_if.priority_req = '0;
    req_if.tag          = '0;
    rsp_if.ready        = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Work out the result of one request and update the shadow queue
  function automatic result_t queue_outcome(logic act, logic signed [PRIO_BITS-1:0] prio,
                                            logic [TAG_BITS-1:0] tag);
    result_t r;
    slot_t   s;
    int      pos;
    r = '0;
    if (act == ACT_INSERT) begin
      if (held_slots.size() >= DEPTH) begin
        r.err = ERR_FULL;
      end else begin
        pos = 0;
        // new entry goes behind every entry of lower or equal priority
        while (pos < held_slots.size() && $signed(held_slots[pos].prio) <= $signed(prio))
          pos++;
        s.prio = prio;
        s.tag  = tag;
        held_slots.insert(pos, s);
        r.err = ERR_OK;
      end
    end else begin
      if (held_slots.size() == 0) begin
        r.err = ERR_EMPTY;
      end else begin
        s        = held_slots.pop_front();
        r.popped = 1'b1;
        r.prio   = s.prio;
        r.tag    = s.tag;
        r.err    = ERR_OK;
      end
    end
    r.empty = (held_slots.size() == 0);
    r.count = CNT_BITS'(held_slots.size());
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("popped=%0b prio=%0d tag=%h empty=%0b count=%0d err=%0d",
                     r.popped, r.prio, r.tag, r.empty, r.count, r.err);
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= SHOW_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Compare a delivered result word with the oldest expectation
  function automatic void check_result(result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      note_fault({"unexpected result word: ", fmt_result(got)});
      return;
    end
    want = awaited_results.pop_front();
    if (got.popped !== want.popped || got.prio !== want.prio || got.tag !== want.tag ||
        got.empty !== want.empty || got.count !== want.count || got.err !== want.err)
      note_fault({"expected ", fmt_result(want), " got ", fmt_result(got)});
  endfunction

  // Monitor both channels; also track cycles with no progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        check_result({rsp_if.popped_valid, rsp_if.out_priority, rsp_if.out_tag,
                      rsp_if.is_empty, rsp_if.entry_count, rsp_if.error_code});
      if (req_if.valid && req_if.ready)
        awaited_results.push_back(queue_outcome(req_if.action, req_if.priority_req,
                                                req_if.tag));
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  // Watchdog on a stuck handshake
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] no word moved for %0d cycles", $realtime, QUIET_LIMIT);
    $display("FAIL sorted_priority_queue");
    $finish;
  end

  // Offer one request word and hold it until it is taken
  task automatic send_word(logic act, logic signed [PRIO_BITS-1:0] prio,
                           logic [TAG_BITS-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.priority_req <= prio;
    req_if.tag          <= tag;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [PRIO_BITS-1:0] pick_prio();
    int unsigned sel;
    sel = $urandom_range(99);
    // narrow band gives plenty of ties
    if (sel < 40) return PRIO_BITS'($signed($urandom_range(6)) - 3);
    if (sel < 45) return {1'b1, {(PRIO_BITS-1){1'b0}}};
    if (sel < 50) return {1'b0, {(PRIO_BITS-1){1'b1}}};
    return PRIO_BITS'($urandom());
  endfunction

  task automatic test_pop_when_empty();
    send_word(ACT_POP, 16'sh1234, 16'hABCD);
  endtask

  // Extremes, ties and an insert into a full queue
  task automatic test_fill_and_overflow();
    send_word(ACT_INSERT, 16'sd0,     16'h0001);
    send_word(ACT_INSERT, -16'sd32768, 16'hFFFF);
    send_word(ACT_INSERT, 16'sd32767, 16'h0000);
    send_word(ACT_INSERT, -16'sd1,    16'h00A5);
    send_word(ACT_INSERT, 16'sd0,     16'h0002);
    send_word(ACT_INSERT, -16'sd32768, 16'h1234);
    send_word(ACT_INSERT, 16'sd32767, 16'h5A5A);
    send_word(ACT_INSERT, 16'sd100,   16'h8001);
    send_word(ACT_INSERT, -16'sd100,  16'h7FFE);
    send_word(ACT_INSERT, 16'sd1,     16'hC3C3);
    send_word(ACT_INSERT, 16'sd0,     16'h0003);
    send_word(ACT_INSERT, -16'sd1,    16'h3C3C);
    send_word(ACT_INSERT, 16'sd7,     16'h0F0F);
    send_word(ACT_INSERT, -16'sd7,    16'hF0F0);
    send_word(ACT_INSERT, 16'sd32767, 16'h5555);
    send_word(ACT_INSERT, -16'sd32768, 16'hAAAA);
    send_word(ACT_INSERT, 16'sd42,    16'hBEEF);
  endtask

  task automatic test_drain_order();
    repeat (7) send_word(ACT_POP, PRIO_BITS'($urandom()), TAG_BITS'($urandom()));
  endtask

  // Bursts that lean towards filling, draining or neither, so both ends are hit often
  task automatic test_random_traffic(int unsigned n_words, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned left;
    int unsigned burst;
    int unsigned pop_pct;
    int unsigned mode;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    left = n_words;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      mode  = $urandom_range(2);
      pop_pct = (mode == 0) ? 15 : (mode == 1) ? 85 : 50;
      while (burst > 0 && left > 0) begin
        send_word(($urandom_range(99) < pop_pct) ? ACT_POP : ACT_INSERT,
                  pick_prio(), TAG_BITS'($urandom()));
        burst--;
        left--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pop_when_empty();
    test_fill_and_overflow();
    test_drain_order();
    test_random_traffic(256, 0, 0);
    test_random_traffic(256, 64, 0);
    test_random_traffic(256, 0, 64);
    test_random_traffic(256, 18, 18);
    req_if.valid <= 1'b0;

    // let the last results drain out
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0)
      note_fault("results still outstanding at the end");

    if (fault_count == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
